// ===== hw/rtl/lsk_pkg.sv =====
package lsk_pkg;

    // fixed field widths
    localparam int IDX_W  = 10;
    localparam int SIDE_W = 11;
    localparam int ACT_W  = 2;

    // signed frequency, squares and kernel numerators
    localparam int K_W    = 11;
    localparam int SQ_W   = 20;
    localparam int XY_W   = 21;
    localparam int DEN_W  = 21;
    localparam int NUM_W  = 22;

    // kernel fraction bits and quotient width (kernel part is at most 1.0)
    localparam int KFRAC  = 18;
    localparam int Q_W    = KFRAC + 1;
    localparam int KR_W   = Q_W + 1;

    // divisor is twice the denominator, remainder stays below it
    localparam int D_W    = DEN_W + 1;
    localparam int R_W    = D_W;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);

    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADJOINT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INVERSE = 2'd2;

    // one lane of the long division
    typedef struct packed {
        logic [R_W-1:0] rem;
        logic [Q_W-1:0] quo;
    } div_lane_t;

    // item flags that travel with the data
    typedef struct packed {
        logic neg_r;
        logic neg_i;
        logic zero_k;
        logic err;
    } item_flags_t;

endpackage

// ===== hw/rtl/lensing_shear_kernel_apply.sv =====
// Applies the Fourier-domain shear kernel to a stream of pixels: each word
// carries a grid row, a column, an action and a complex value, and gives one
// word holding the value times the kernel (forward) or its conjugate (adjoint
// or inverse), rounded and clipped, with a saturation flag and an index error
// flag. One pixel is taken every cycle unless the pipeline is held, and each
// result passes through three set-up stages, one stage per quotient bit of the
// 19-step kernel divider and four stages of multiply, sum and rounding. The
// whole pipeline holds while a finished result is stalled at the output.
// grid_side must be written only while the pipeline is empty; the block does
// not enforce this. grid_side is clamped to the range 2 to min(MAX_SIDE, 2047).
module lensing_shear_kernel_apply #(
    parameter int MAX_SIDE   = 1024,
    parameter int VALUE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              grid_side_we,
    input  logic [lsk_pkg::SIDE_W-1:0]        grid_side_data,

    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [lsk_pkg::ACT_W-1:0]         action,
    input  logic [lsk_pkg::IDX_W-1:0]         row_index,
    input  logic [lsk_pkg::IDX_W-1:0]         col_index,
    input  logic signed [VALUE_BITS-1:0]      value_re,
    input  logic signed [VALUE_BITS-1:0]      value_im,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [VALUE_BITS-1:0]      result_re,
    output logic signed [VALUE_BITS-1:0]      result_im,
    output logic                              saturated,
    output logic                              index_error
);
    import lsk_pkg::*;

    localparam int PW = 2 * VALUE_BITS + $bits(item_flags_t);

    logic [SIDE_W-1:0] grid_side_reg;
    logic              en;

    logic                         f_valid;
    div_lane_t                    f_lane_r;
    div_lane_t                    f_lane_i;
    logic [D_W-1:0]               f_dsor;
    logic [Q_W-1:0]               f_nlow;
    item_flags_t                  f_flags;
    logic signed [VALUE_BITS-1:0] f_vr;
    logic signed [VALUE_BITS-1:0] f_vi;

    logic      d_valid [Q_W+1];
    div_lane_t d_lane_r [Q_W+1];
    div_lane_t d_lane_i [Q_W+1];
    logic [D_W-1:0] d_dsor [Q_W+1];
    logic [Q_W-1:0] d_nlow [Q_W+1];
    logic [PW-1:0]  d_pass [Q_W+1];

    item_flags_t                  b_flags;
    logic signed [VALUE_BITS-1:0] b_vr;
    logic signed [VALUE_BITS-1:0] b_vi;

    // grid side register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_side_reg <= SIDE_RESET;
        else if (grid_side_we)
            grid_side_reg <= grid_side_data;
    end

    // pipeline advances unless a finished word is held at the output
    assign en          = !(result_valid && result_stall);
    assign pixel_stall = !en;

    lsk_front #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pixel_valid),
        .side      (grid_side_reg),
        .action    (action),
        .row_index (row_index),
        .col_index (col_index),
        .value_re  (value_re),
        .value_im  (value_im),
        .valid_out (f_valid),
        .lane_r    (f_lane_r),
        .lane_i    (f_lane_i),
        .dsor      (f_dsor),
        .nlow      (f_nlow),
        .flags     (f_flags),
        .vr        (f_vr),
        .vi        (f_vi)
    );

    assign d_valid[0]  = f_valid;
    assign d_lane_r[0] = f_lane_r;
    assign d_lane_i[0] = f_lane_i;
    assign d_dsor[0]   = f_dsor;
    assign d_nlow[0]   = f_nlow;
    assign d_pass[0]   = {f_flags, f_vr, f_vi};

    // kernel divider, one quotient bit per stage
    for (genvar s = 0; s < Q_W; s++)
    begin : g_div
        lsk_div_step #(
            .PW  (PW),
            .BIT (Q_W - 1 - s)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (d_valid[s]),
            .lane_r_in  (d_lane_r[s]),
            .lane_i_in  (d_lane_i[s]),
            .dsor_in    (d_dsor[s]),
            .nlow_in    (d_nlow[s]),
            .pass_in    (d_pass[s]),
            .valid_out  (d_valid[s+1]),
            .lane_r_out (d_lane_r[s+1]),
            .lane_i_out (d_lane_i[s+1]),
            .dsor_out   (d_dsor[s+1]),
            .nlow_out   (d_nlow[s+1]),
            .pass_out   (d_pass[s+1])
        );
    end

    assign {b_flags, b_vr, b_vi} = d_pass[Q_W];

    lsk_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (d_valid[Q_W]),
        .quo_r       (d_lane_r[Q_W].quo),
        .quo_i       (d_lane_i[Q_W].quo),
        .flags       (b_flags),
        .vr          (b_vr),
        .vi          (b_vi),
        .valid_out   (result_valid),
        .result_re   (result_re),
        .result_im   (result_im),
        .saturated   (saturated),
        .index_error (index_error)
    );

endmodule

// ===== hw/rtl/lsk_front.sv =====
module lsk_front #(
    parameter int MAX_SIDE   = 1024,
    parameter int VALUE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid_in,
    input  logic [lsk_pkg::SIDE_W-1:0]        side,
    input  logic [lsk_pkg::ACT_W-1:0]         action,
    input  logic [lsk_pkg::IDX_W-1:0]         row_index,
    input  logic [lsk_pkg::IDX_W-1:0]         col_index,
    input  logic signed [VALUE_BITS-1:0]      value_re,
    input  logic signed [VALUE_BITS-1:0]      value_im,
    output logic                              valid_out,
    output lsk_pkg::div_lane_t                lane_r,
    output lsk_pkg::div_lane_t                lane_i,
    output logic [lsk_pkg::D_W-1:0]           dsor,
    output logic [lsk_pkg::Q_W-1:0]           nlow,
    output lsk_pkg::item_flags_t              flags,
    output logic signed [VALUE_BITS-1:0]      vr,
    output logic signed [VALUE_BITS-1:0]      vi
);
    import lsk_pkg::*;

    localparam logic [SIDE_W-1:0] SIDE_MAX =
        (MAX_SIDE > 2047) ? SIDE_W'(2047) : SIDE_W'(MAX_SIDE);

    logic [SIDE_W-1:0] side_eff;
    logic              err_next;
    logic [K_W-1:0]    ky_next;
    logic [K_W-1:0]    kx_next;
    logic [K_W:0]      ky_wrap;
    logic [K_W:0]      kx_wrap;

    logic                         v1_reg;
    logic                         err1_reg;
    logic                         conj1_reg;
    logic signed [K_W-1:0]        ky_reg;
    logic signed [K_W-1:0]        kx_reg;
    logic signed [VALUE_BITS-1:0] vr1_reg;
    logic signed [VALUE_BITS-1:0] vi1_reg;

    logic                         v2_reg;
    logic                         err2_reg;
    logic                         conj2_reg;
    logic [SQ_W-1:0]              kyy_reg;
    logic [SQ_W-1:0]              kxx_reg;
    logic signed [XY_W-1:0]       kxy_reg;
    logic signed [VALUE_BITS-1:0] vr2_reg;
    logic signed [VALUE_BITS-1:0] vi2_reg;

    logic signed [2*K_W-1:0] kyy_full;
    logic signed [2*K_W-1:0] kxx_full;
    logic signed [2*K_W-1:0] kxy_full;

    logic [DEN_W-1:0]        den;
    logic signed [NUM_W-1:0] num_r;
    logic signed [NUM_W-1:0] num_i;
    logic [NUM_W-1:0]        abs_r;
    logic [NUM_W-1:0]        abs_i;
    logic [R_W-1:0]          rem_top;

    logic                         v3_reg;
    div_lane_t                    lane_r_reg;
    div_lane_t                    lane_i_reg;
    logic [D_W-1:0]               dsor_reg;
    logic [Q_W-1:0]               nlow_reg;
    item_flags_t                  flags_reg;
    logic signed [VALUE_BITS-1:0] vr3_reg;
    logic signed [VALUE_BITS-1:0] vi3_reg;

    // side clamp, range check and wrap to signed frequency
    always_comb
    begin
        side_eff = side;
        if (side < SIDE_MIN)
            side_eff = SIDE_MIN;
        if (side > SIDE_MAX)
            side_eff = SIDE_MAX;
        err_next = ({1'b0, row_index} >= side_eff) || ({1'b0, col_index} >= side_eff);
        ky_wrap  = {2'b00, row_index} - {1'b0, side_eff};
        kx_wrap  = {2'b00, col_index} - {1'b0, side_eff};
        ky_next  = ({row_index, 1'b0} < side_eff) ? {1'b0, row_index} : ky_wrap[K_W-1:0];
        kx_next  = ({col_index, 1'b0} < side_eff) ? {1'b0, col_index} : kx_wrap[K_W-1:0];
    end

    // squares and cross term
    assign kyy_full = ky_reg * ky_reg;
    assign kxx_full = kx_reg * kx_reg;
    assign kxy_full = kx_reg * ky_reg;

    // numerators, magnitudes and division set-up
    always_comb
    begin
        den     = {1'b0, kyy_reg} + {1'b0, kxx_reg};
        num_r   = $signed({2'b00, kyy_reg}) - $signed({2'b00, kxx_reg});
        num_i   = {kxy_reg, 1'b0};
        abs_r   = num_r[NUM_W-1] ? -num_r : num_r;
        abs_i   = num_i[NUM_W-1] ? -num_i : num_i;
        rem_top = R_W'(den[DEN_W-1:Q_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg  <= err_next;
            conj1_reg <= (action != ACT_FORWARD);
            ky_reg    <= ky_next;
            kx_reg    <= kx_next;
            vr1_reg   <= value_re;
            vi1_reg   <= value_im;

            err2_reg  <= err1_reg;
            conj2_reg <= conj1_reg;
            kyy_reg   <= kyy_full[SQ_W-1:0];
            kxx_reg   <= kxx_full[SQ_W-1:0];
            kxy_reg   <= kxy_full[XY_W-1:0];
            vr2_reg   <= vr1_reg;
            vi2_reg   <= vi1_reg;

            lane_r_reg.rem   <= R_W'(abs_r[DEN_W-1:0]) + rem_top;
            lane_r_reg.quo   <= '0;
            lane_i_reg.rem   <= R_W'(abs_i[DEN_W-1:0]) + rem_top;
            lane_i_reg.quo   <= '0;
            dsor_reg         <= {den, 1'b0};
            nlow_reg         <= den[Q_W-1:0];
            flags_reg.neg_r  <= num_r[NUM_W-1];
            flags_reg.neg_i  <= num_i[NUM_W-1] ^ conj2_reg;
            flags_reg.zero_k <= (den == '0);
            flags_reg.err    <= err2_reg;
            vr3_reg          <= vr2_reg;
            vi3_reg          <= vi2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign lane_r    = lane_r_reg;
    assign lane_i    = lane_i_reg;
    assign dsor      = dsor_reg;
    assign nlow      = nlow_reg;
    assign flags     = flags_reg;
    assign vr        = vr3_reg;
    assign vi        = vi3_reg;

endmodule

// ===== hw/rtl/lsk_div_step.sv =====
module lsk_div_step #(
    parameter int PW  = 52,
    parameter int BIT = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  lsk_pkg::div_lane_t       lane_r_in,
    input  lsk_pkg::div_lane_t       lane_i_in,
    input  logic [lsk_pkg::D_W-1:0]  dsor_in,
    input  logic [lsk_pkg::Q_W-1:0]  nlow_in,
    input  logic [PW-1:0]            pass_in,
    output logic                     valid_out,
    output lsk_pkg::div_lane_t       lane_r_out,
    output lsk_pkg::div_lane_t       lane_i_out,
    output logic [lsk_pkg::D_W-1:0]  dsor_out,
    output logic [lsk_pkg::Q_W-1:0]  nlow_out,
    output logic [PW-1:0]            pass_out
);
    import lsk_pkg::*;

    logic [R_W:0] trial_r;
    logic [R_W:0] trial_i;
    logic         ge_r;
    logic         ge_i;
    logic [R_W:0] diff_r;
    logic [R_W:0] diff_i;
    div_lane_t    lane_r_next;
    div_lane_t    lane_i_next;

    logic         valid_reg;
    div_lane_t    lane_r_reg;
    div_lane_t    lane_i_reg;
    logic [D_W-1:0] dsor_reg;
    logic [Q_W-1:0] nlow_reg;
    logic [PW-1:0]  pass_reg;

    // one restoring division bit on both lanes
    always_comb
    begin
        trial_r = {lane_r_in.rem, nlow_in[BIT]};
        trial_i = {lane_i_in.rem, nlow_in[BIT]};
        ge_r    = trial_r >= {1'b0, dsor_in};
        ge_i    = trial_i >= {1'b0, dsor_in};
        diff_r  = trial_r - {1'b0, dsor_in};
        diff_i  = trial_i - {1'b0, dsor_in};
        lane_r_next.rem = ge_r ? diff_r[R_W-1:0] : trial_r[R_W-1:0];
        lane_i_next.rem = ge_i ? diff_i[R_W-1:0] : trial_i[R_W-1:0];
        lane_r_next.quo = {lane_r_in.quo[Q_W-2:0], ge_r};
        lane_i_next.quo = {lane_i_in.quo[Q_W-2:0], ge_i};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_r_reg <= lane_r_next;
            lane_i_reg <= lane_i_next;
            dsor_reg   <= dsor_in;
            nlow_reg   <= nlow_in;
            pass_reg   <= pass_in;
        end
    end

    assign valid_out  = valid_reg;
    assign lane_r_out = lane_r_reg;
    assign lane_i_out = lane_i_reg;
    assign dsor_out   = dsor_reg;
    assign nlow_out   = nlow_reg;
    assign pass_out   = pass_reg;

endmodule

// ===== hw/rtl/lsk_back.sv =====
module lsk_back #(
    parameter int VALUE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic [lsk_pkg::Q_W-1:0]       quo_r,
    input  logic [lsk_pkg::Q_W-1:0]       quo_i,
    input  lsk_pkg::item_flags_t          flags,
    input  logic signed [VALUE_BITS-1:0]  vr,
    input  logic signed [VALUE_BITS-1:0]  vi,
    output logic                          valid_out,
    output logic signed [VALUE_BITS-1:0]  result_re,
    output logic signed [VALUE_BITS-1:0]  result_im,
    output logic                          saturated,
    output logic                          index_error
);
    import lsk_pkg::*;

    localparam int P_W  = KR_W + VALUE_BITS;
    localparam int S_W  = P_W + 1;
    localparam int RD_W = S_W + 1 - KFRAC;
    localparam logic [S_W:0]    HALF    = (S_W + 1)'(1) << (KFRAC - 1);
    localparam logic [RD_W-1:0] LIM_NEG = RD_W'(1) << (VALUE_BITS - 1);
    localparam logic [RD_W-1:0] LIM_POS = LIM_NEG - RD_W'(1);

    logic                         v1_reg;
    logic                         err1_reg;
    logic signed [KR_W-1:0]       kr_reg;
    logic signed [KR_W-1:0]       ki_reg;
    logic signed [VALUE_BITS-1:0] vr1_reg;
    logic signed [VALUE_BITS-1:0] vi1_reg;

    logic                    v2_reg;
    logic                    err2_reg;
    logic signed [P_W-1:0]   p_rr_reg;
    logic signed [P_W-1:0]   p_ii_reg;
    logic signed [P_W-1:0]   p_ri_reg;
    logic signed [P_W-1:0]   p_ir_reg;

    logic                    v3_reg;
    logic                    err3_reg;
    logic signed [S_W-1:0]   sr_reg;
    logic signed [S_W-1:0]   si_reg;

    logic signed [KR_W-1:0]  kr_next;
    logic signed [KR_W-1:0]  ki_next;
    logic [S_W-1:0]          mag_r;
    logic [S_W-1:0]          mag_i;
    logic [S_W:0]            rnd_r;
    logic [S_W:0]            rnd_i;
    logic [RD_W-1:0]         q_r;
    logic [RD_W-1:0]         q_i;
    logic [RD_W-1:0]         c_r;
    logic [RD_W-1:0]         c_i;
    logic                    sat_r;
    logic                    sat_i;
    logic [RD_W-1:0]         o_r;
    logic [RD_W-1:0]         o_i;

    logic                         v4_reg;
    logic signed [VALUE_BITS-1:0] res_re_reg;
    logic signed [VALUE_BITS-1:0] res_im_reg;
    logic                         sat_reg;
    logic                         err4_reg;

    // signed kernel parts, zero at the origin
    always_comb
    begin
        kr_next = flags.neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
        ki_next = flags.neg_i ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
        if (flags.zero_k)
        begin
            kr_next = '0;
            ki_next = '0;
        end
    end

    // round half away from zero, then clip
    always_comb
    begin
        mag_r = sr_reg[S_W-1] ? S_W'(-sr_reg) : S_W'(sr_reg);
        mag_i = si_reg[S_W-1] ? S_W'(-si_reg) : S_W'(si_reg);
        rnd_r = {1'b0, mag_r} + HALF;
        rnd_i = {1'b0, mag_i} + HALF;
        q_r   = rnd_r[S_W:KFRAC];
        q_i   = rnd_i[S_W:KFRAC];
        c_r   = q_r;
        c_i   = q_i;
        sat_r = 1'b0;
        sat_i = 1'b0;
        if (sr_reg[S_W-1] && (q_r > LIM_NEG))
        begin
            c_r   = LIM_NEG;
            sat_r = 1'b1;
        end
        else if (!sr_reg[S_W-1] && (q_r > LIM_POS))
        begin
            c_r   = LIM_POS;
            sat_r = 1'b1;
        end
        if (si_reg[S_W-1] && (q_i > LIM_NEG))
        begin
            c_i   = LIM_NEG;
            sat_i = 1'b1;
        end
        else if (!si_reg[S_W-1] && (q_i > LIM_POS))
        begin
            c_i   = LIM_POS;
            sat_i = 1'b1;
        end
        o_r = sr_reg[S_W-1] ? -c_r : c_r;
        o_i = si_reg[S_W-1] ? -c_i : c_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg <= flags.err;
            kr_reg   <= kr_next;
            ki_reg   <= ki_next;
            vr1_reg  <= vr;
            vi1_reg  <= vi;

            err2_reg <= err1_reg;
            p_rr_reg <= kr_reg * vr1_reg;
            p_ii_reg <= ki_reg * vi1_reg;
            p_ri_reg <= kr_reg * vi1_reg;
            p_ir_reg <= ki_reg * vr1_reg;

            err3_reg <= err2_reg;
            sr_reg   <= S_W'(p_rr_reg) - S_W'(p_ii_reg);
            si_reg   <= S_W'(p_ri_reg) + S_W'(p_ir_reg);

            err4_reg <= err3_reg;
            if (err3_reg)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else
            begin
                res_re_reg <= o_r[VALUE_BITS-1:0];
                res_im_reg <= o_i[VALUE_BITS-1:0];
                sat_reg    <= sat_r | sat_i;
            end
        end
    end

    assign valid_out   = v4_reg;
    assign result_re   = res_re_reg;
    assign result_im   = res_im_reg;
    assign saturated   = sat_reg;
    assign index_error = err4_reg;

endmodule
